@@ design/substring_search_matcher_top_defines.svh @@
// Assertion macros shared by the substring matcher checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef SUBSTRING_SEARCH_MATCHER_TOP_DEFINES_SVH
`define SUBSTRING_SEARCH_MATCHER_TOP_DEFINES_SVH

// Implication on the same edge, disabled while reset is asserted
`define SSM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("%m: assertion failed");

// Implication on the following edge, disabled while reset is asserted
`define SSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("%m: assertion failed");

`endif

@@ design/ssm_pkg.sv @@
// Package for the substring matcher: action codes, sizes, inter-module structs.
// No dependencies.
`default_nettype none

package ssm_pkg;

	localparam int MAX_PATTERN = 32;

	// Input action codes
	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_TEXT   = 2'd2;
	localparam logic [1:0] ACT_END    = 2'd3;

	localparam logic [7:0] NUL_BYTE = 8'h00;

	// Command broadcast from the controller to every cell
	typedef struct packed {
		logic       clr_pat;   // drop the whole pattern
		logic       clr_hist;  // clear partial-match bits
		logic       append;    // store data in the first free cell
		logic       text;      // compare data against the pattern
		logic [7:0] data;
	} cell_cmd_t;

	// Status gathered from the chain of cells
	typedef struct packed {
		logic hit;    // last pattern cell matched on this text beat
		logic full;   // every cell holds a pattern byte
		logic empty;  // no pattern byte stored
	} chain_stat_t;

endpackage

`default_nettype wire

@@ design/ssm_cell.sv @@
// One matcher cell: a pattern byte, its occupancy bit and its partial-match bit.
// Depends on ssm_pkg.
`default_nettype none

module ssm_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  ssm_pkg::cell_cmd_t   cmd,
	input  wire                  prev_active,
	input  wire                  prev_partial,
	input  wire                  next_active,
	output logic                 active,
	output logic                 partial,
	output logic                 hit
);

	logic       active_q;
	logic       partial_q;
	logic [7:0] pat_q;
	logic       wr;
	logic       match;

	// First free cell takes the appended byte
	assign wr    = cmd.append & ~active_q & prev_active;
	// Prefix through this cell matches the latest text byte
	assign match = active_q & prev_partial & (pat_q == cmd.data);

	// Occupancy and partial-match state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			partial_q <= 1'b0;
		end else begin
			if (cmd.clr_pat) begin
				active_q <= 1'b0;
			end else if (wr) begin
				active_q <= 1'b1;
			end
			if (cmd.clr_hist) begin
				partial_q <= 1'b0;
			end else if (cmd.text) begin
				partial_q <= match;
			end
		end
	end

	// Pattern byte storage, no reset
	always_ff @(posedge clk) begin
		if (wr) begin
			pat_q <= cmd.data;
		end
	end

	assign active  = active_q;
	assign partial = partial_q;
	// Whole pattern matched: this is the last occupied cell
	assign hit     = cmd.text & match & ~next_active;

endmodule

`default_nettype wire

@@ design/ssm_ctrl.sv @@
// Matcher controller: beat decode, found/truncation flags, result register.
// Depends on ssm_pkg.
`default_nettype none

module ssm_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire  [1:0]            action,
	input  wire  [7:0]            data,
	output logic                  out_valid,
	input  wire                   out_stall,
	output logic                  found,
	output logic                  pattern_truncated,
	output ssm_pkg::cell_cmd_t    cmd,
	input  ssm_pkg::chain_stat_t  stat
);

	logic acc;
	logic is_append;
	logic is_text;
	logic is_end;
	logic drop;
	logic found_q;
	logic trunc_q;
	logic out_valid_q;
	logic found_res_q;
	logic trunc_res_q;

	// Hold input only while a result waits
	assign in_stall = out_valid_q & out_stall;
	assign acc      = in_valid & ~in_stall;

	// Beat decode
	assign is_append = acc & (action == ssm_pkg::ACT_APPEND);
	assign is_text   = acc & (action == ssm_pkg::ACT_TEXT) & (data != ssm_pkg::NUL_BYTE);
	assign is_end    = acc & ((action == ssm_pkg::ACT_END) |
		((action == ssm_pkg::ACT_TEXT) & (data == ssm_pkg::NUL_BYTE)));
	assign drop      = is_append & ((data == ssm_pkg::NUL_BYTE) | stat.full);

	always_comb begin
		cmd          = '0;
		cmd.clr_pat  = acc & (action == ssm_pkg::ACT_CLEAR);
		cmd.clr_hist = cmd.clr_pat | is_append | is_end;
		cmd.append   = is_append & ~drop;
		cmd.text     = is_text;
		cmd.data     = data;
	end

	// Sticky flags and the result valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			trunc_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_hist) begin
				found_q <= 1'b0;
			end else if (is_text & stat.hit) begin
				found_q <= 1'b1;
			end
			if (cmd.clr_pat) begin
				trunc_q <= 1'b0;
			end else if (drop) begin
				trunc_q <= 1'b1;
			end
			if (is_end) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result beat payload
	always_ff @(posedge clk) begin
		if (is_end) begin
			found_res_q <= found_q | stat.empty;
			trunc_res_q <= trunc_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign found             = found_res_q;
	assign pattern_truncated = trunc_res_q;

endmodule

`default_nettype wire

@@ design/substring_search_matcher_top.sv @@
// Substring matcher top: controller plus a row of MAX_PATTERN matcher cells.
// Depends on ssm_pkg, ssm_cell, ssm_ctrl.
// Throughput: one beat per cycle while the result register is free.
// The result beat shows in the cycle after the end-of-text beat is accepted.
// Each text beat updates every cell's partial-match bit.
// Reset: asynchronous, clears pattern length, flags and match history.
`default_nettype none

module substring_search_matcher_top #(
	parameter int MAX_PATTERN = ssm_pkg::MAX_PATTERN
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [1:0] action,
	input  wire  [7:0] data,
	output logic       out_valid,
	input  wire        out_stall,
	output logic       found,
	output logic       pattern_truncated
);

	ssm_pkg::cell_cmd_t   cmd;
	ssm_pkg::chain_stat_t stat;
	logic [MAX_PATTERN-1:0] active;
	logic [MAX_PATTERN-1:0] partial;
	logic [MAX_PATTERN-1:0] hit;

	ssm_ctrl u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.action            (action),
		.data              (data),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.found             (found),
		.pattern_truncated (pattern_truncated),
		.cmd               (cmd),
		.stat              (stat)
	);

	// Row of cells, each chained to its neighbors
	for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
		logic prev_a;
		logic prev_p;
		logic next_a;
		if (g == 0) begin : g_first
			assign prev_a = 1'b1;
			assign prev_p = 1'b1;
		end else begin : g_inner
			assign prev_a = active[g-1];
			assign prev_p = partial[g-1];
		end
		if (g == MAX_PATTERN - 1) begin : g_last
			assign next_a = 1'b0;
		end else begin : g_body
			assign next_a = active[g+1];
		end
		ssm_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd),
			.prev_active  (prev_a),
			.prev_partial (prev_p),
			.next_active  (next_a),
			.active       (active[g]),
			.partial      (partial[g]),
			.hit          (hit[g])
		);
	end

	// Chain status
	always_comb begin
		stat       = '0;
		stat.hit   = |hit;
		stat.full  = active[MAX_PATTERN-1];
		stat.empty = ~active[0];
	end

endmodule

`default_nettype wire

@@ design/ssm_checker.sv @@
// Port-level checker for the substring matcher, bound to the top level.
// Depends on ssm_pkg and substring_search_matcher_top_defines.svh.
`default_nettype none
`include "substring_search_matcher_top_defines.svh"

module ssm_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_stall,
	input wire [1:0] action,
	input wire [7:0] data,
	input wire       out_valid,
	input wire       out_stall,
	input wire       found,
	input wire       pattern_truncated
);

	logic acc;
	logic acc_clear;
	logic acc_end;
	logic acc_end_any;

	assign acc         = in_valid & ~in_stall;
	assign acc_clear   = acc & (action == ssm_pkg::ACT_CLEAR);
	assign acc_end     = acc & (action == ssm_pkg::ACT_END);
	assign acc_end_any = acc_end | (acc & (action == ssm_pkg::ACT_TEXT) & (data == 8'h00));

	// Stalled result beat holds
	`SSM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(found) && $stable(pattern_truncated))
	// Input is held back only by a waiting result
	`SSM_ASSERT_SAME(a_stall_cause, clk, arst_n, in_stall, out_valid)
	// End of text always yields a result beat
	`SSM_ASSERT_NEXT(a_end_result, clk, arst_n, acc_end_any, out_valid)
	// Clear directly followed by end of text reports a match, no truncation
	`SSM_ASSERT_NEXT(a_empty_match, clk, arst_n, $past(acc_clear) && acc_end, found && !pattern_truncated)
	// Beats other than end of text do not create a result
	`SSM_ASSERT_NEXT(a_no_spurious, clk, arst_n, !out_valid && !acc_end_any, !out_valid)

endmodule

bind substring_search_matcher_top ssm_checker u_ssm_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_stall          (in_stall),
	.action            (action),
	.data              (data),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.found             (found),
	.pattern_truncated (pattern_truncated)
);

`default_nettype wire
